/* rtl/tap_burst_rate_detector_assert.svh */
// Assertion macros shared by the detector RTL.
`ifndef TAP_BURST_RATE_DETECTOR_ASSERT_SVH
`define TAP_BURST_RATE_DETECTOR_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define TBRD_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TBRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tbrd_pkg.sv */
package tbrd_pkg;

    // Fixed field widths
    localparam int EVENT_TIME_W   = 32;
    localparam int LIMIT_W        = 32;
    localparam int IV_W           = 16;
    localparam int HITS_SEEN_W    = 4;
    localparam int WINDOW_TOTAL_W = 19;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1000;

    // Command codes
    localparam logic CMD_HIT   = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COUNT,
        PH_OPEN
    } t_phase;

    typedef struct packed {
        logic                      lock_open;
        logic [HITS_SEEN_W-1:0]    hits_seen;
        logic [WINDOW_TOTAL_W-1:0] window_total;
        logic                      armed;
    } t_result;

endpackage

/* rtl/tbrd_in_if.sv */
interface tbrd_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [tbrd_pkg::EVENT_TIME_W-1:0]   event_time;
    logic                                level_confirmed;

    modport source (output valid, output cmd, output event_time, output level_confirmed,
                    input ready);
    modport sink   (input valid, input cmd, input event_time, input level_confirmed,
                    output ready);
endinterface

/* rtl/tbrd_out_if.sv */
interface tbrd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  lock_open;
    logic [tbrd_pkg::HITS_SEEN_W-1:0]      hits_seen;
    logic [tbrd_pkg::WINDOW_TOTAL_W-1:0]   window_total;
    logic                                  armed;

    modport source (output valid, output lock_open, output hits_seen, output window_total,
                    output armed, input ready);
    modport sink   (input valid, input lock_open, input hits_seen, input window_total,
                    input armed, output ready);
endinterface

/* rtl/tbrd_cfg_if.sv */
interface tbrd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tbrd_pkg::LIMIT_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tap_burst_rate_detector.sv */
// A result beat is computed combinationally from its input beat and registered in the output stage.
// Throughput: one beat per cycle while the output stage has a free slot; each hit in
//   PH_COUNT read-modify-writes the interval ring, prefetching from the updated pointer.
// Input stays ready while the two-deep output stage has a free slot.
// Reset (synchronous, active low) clears phase, pointer, tally, sum and pending flag
//   at once and sets r_limit to 1000; ring entries read as zero until refilled.
`include "tap_burst_rate_detector_assert.svh"

module tap_burst_rate_detector #(
    parameter int HITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbrd_in_if.sink     i_in,
    tbrd_out_if.source  o_out,
    tbrd_cfg_if.sink    i_cfg
);

    localparam int RING_LEN = HITS - 1;
    localparam int PTR_W    = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
    localparam int TALLY_W  = $clog2(HITS + 1);
    localparam int SUM_W    = $clog2(RING_LEN * 65535 + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(RING_LEN - 1);
    localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(HITS);

    // State
    tbrd_pkg::t_phase               r_phase, n_phase, s_phase;
    logic [PTR_W-1:0]               r_ptr, n_ptr, s_ptr;
    logic [TALLY_W-1:0]             r_tally, n_tally, s_tally;
    logic [SUM_W-1:0]               r_sum, n_sum, s_sum;
    logic [tbrd_pkg::EVENT_TIME_W-1:0] r_last, n_last;
    logic                           r_pend, n_pend;
    logic [tbrd_pkg::LIMIT_W-1:0]   r_limit;

    // Interval ring memory and its registered read port
    logic [tbrd_pkg::IV_W-1:0]      ring_mem [RING_LEN];
    logic [tbrd_pkg::IV_W-1:0]      r_old;

    logic                           acc;
    logic                           hit;
    logic                           rst_req;
    logic                           ring_wr;
    logic                           fired;
    logic                           clear;
    logic                           res_ready;
    logic [tbrd_pkg::IV_W-1:0]      old_entry;
    logic [tbrd_pkg::IV_W-1:0]      iv;
    logic [SUM_W-1:0]               sum_hit;
    tbrd_pkg::t_result              res;

    tbrd_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .o_ready (res_ready),
        .i_data  (res),
        .o_out   (o_out)
    );

    assign i_in.ready  = res_ready;
    assign i_cfg.ready = 1'b1;
    assign acc     = i_in.valid && res_ready;
    assign rst_req = acc && (i_in.cmd == tbrd_pkg::CMD_RESET);
    assign hit     = acc && (i_in.cmd == tbrd_pkg::CMD_HIT) && i_in.level_confirmed
                     && (r_phase != tbrd_pkg::PH_OPEN);
    assign ring_wr = hit && (r_phase == tbrd_pkg::PH_COUNT);

    // Ring entry at the pointer counts only once the ring has been filled
    assign old_entry = (r_tally >= TALLY_MAX) ? r_old : '0;
    assign iv        = tbrd_pkg::IV_W'(i_in.event_time - r_last);
    assign sum_hit   = r_sum - SUM_W'(old_entry) + SUM_W'(iv);

    // Datapath for one beat
    always_comb begin
        s_tally = r_tally;
        s_sum   = r_sum;
        s_ptr   = r_ptr;
        if (hit) begin
            if (r_phase == tbrd_pkg::PH_IDLE) begin
                s_tally = TALLY_W'(1);
            end else begin
                s_tally = (r_tally < TALLY_MAX) ? r_tally + TALLY_W'(1) : TALLY_MAX;
                s_sum   = sum_hit;
                s_ptr   = (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
            end
        end
        // reset while open reports the cleared sequence
        if (rst_req && (r_phase == tbrd_pkg::PH_OPEN)) begin
            s_tally = '0;
            s_sum   = '0;
            s_ptr   = '0;
        end
    end

    // Phase next state
    always_comb begin
        s_phase = r_phase;
        case (r_phase)
            tbrd_pkg::PH_IDLE: begin
                if (hit) s_phase = tbrd_pkg::PH_COUNT;
            end
            tbrd_pkg::PH_COUNT: begin
                if (hit && (s_tally >= TALLY_MAX)
                    && ({{(tbrd_pkg::LIMIT_W-SUM_W){1'b0}}, s_sum} <= r_limit)) begin
                    s_phase = tbrd_pkg::PH_OPEN;
                end
            end
            tbrd_pkg::PH_OPEN: begin
                if (rst_req) s_phase = tbrd_pkg::PH_IDLE;
            end
            default: s_phase = tbrd_pkg::PH_IDLE;
        endcase
    end

    // Phase outputs: firing, sequence clear, result fields
    always_comb begin
        fired = (r_phase == tbrd_pkg::PH_COUNT) && (s_phase == tbrd_pkg::PH_OPEN);
        clear = (rst_req && (r_phase == tbrd_pkg::PH_OPEN)) || (fired && r_pend);
        res.lock_open    = (s_phase == tbrd_pkg::PH_OPEN);
        res.hits_seen    = tbrd_pkg::HITS_SEEN_W'(s_tally);
        res.window_total = tbrd_pkg::WINDOW_TOTAL_W'(s_sum);
        res.armed        = (s_phase != tbrd_pkg::PH_IDLE);
    end

    // Register next values
    always_comb begin
        n_phase = clear ? tbrd_pkg::PH_IDLE : s_phase;
        n_tally = clear ? '0 : s_tally;
        n_sum   = clear ? '0 : s_sum;
        n_ptr   = clear ? '0 : s_ptr;
        n_last  = hit ? i_in.event_time : r_last;
        if (clear) begin
            n_pend = 1'b0;
        end else if (rst_req) begin
            n_pend = 1'b1;
        end else begin
            n_pend = r_pend;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tbrd_pkg::PH_IDLE;
            r_ptr   <= '0;
            r_tally <= '0;
            r_sum   <= '0;
            r_last  <= '0;
            r_pend  <= 1'b0;
            r_limit <= tbrd_pkg::LIMIT_RESET;
        end else begin
            r_phase <= n_phase;
            r_ptr   <= n_ptr;
            r_tally <= n_tally;
            r_sum   <= n_sum;
            r_last  <= n_last;
            r_pend  <= n_pend;
            if (i_cfg.valid) r_limit <= i_cfg.data;
        end
    end

    // Ring write at the current pointer, prefetch at the next one (forward on overlap)
    always_ff @(posedge i_clk) begin
        if (ring_wr) ring_mem[r_ptr] <= iv;
        if (ring_wr && (n_ptr == r_ptr)) begin
            r_old <= iv;
        end else begin
            r_old <= ring_mem[n_ptr];
        end
    end

    // Assertions
    `TBRD_ASSERT(a_open_full, i_clk, i_rst_n,
        (r_phase != tbrd_pkg::PH_OPEN) || (r_tally == TALLY_MAX),
        "lock open without full tally")
    `TBRD_ASSERT(a_idle_empty, i_clk, i_rst_n,
        (r_phase != tbrd_pkg::PH_IDLE) || ((r_sum == '0) && (r_ptr == '0)),
        "idle with ring state left")
    `TBRD_ASSERT_NXT(a_open_reset, i_clk, i_rst_n,
        rst_req && (r_phase == tbrd_pkg::PH_OPEN),
        (r_phase == tbrd_pkg::PH_IDLE) && (r_tally == '0) && !r_pend,
        "reset while open did not clear")
    `TBRD_ASSERT_NXT(a_fire_pend, i_clk, i_rst_n, fired && r_pend,
        (r_phase == tbrd_pkg::PH_IDLE) && (r_sum == '0),
        "pending reset not applied on firing")

endmodule

/* rtl/tbrd_out_skid.sv */
// Two-deep output stage: output register plus skid register.
module tbrd_out_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tbrd_pkg::t_result   i_data,
    tbrd_out_if.source          o_out
);

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    tbrd_pkg::t_result r_out, n_out;
    tbrd_pkg::t_result r_skid, n_skid;
    logic              take;
    logic              acc;

    assign o_ready = !r_skid_valid;
    assign acc     = i_valid && !r_skid_valid;
    assign take    = r_out_valid && o_out.ready;

    // Next-value selection
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = acc;
            end
        end else if (acc) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.lock_open    = r_out.lock_open;
    assign o_out.hits_seen    = r_out.hits_seen;
    assign o_out.window_total = r_out.window_total;
    assign o_out.armed        = r_out.armed;

endmodule

/* tb/tbrd_lock_checker.sv */
module tbrd_lock_checker #(
    parameter int HITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_cmd,
    input  logic [tbrd_pkg::EVENT_TIME_W-1:0]   i_event_time,
    input  logic                                i_level_confirmed,
    // result channel
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_lock_open,
    input  logic [tbrd_pkg::HITS_SEEN_W-1:0]    i_hits_seen,
    input  logic [tbrd_pkg::WINDOW_TOTAL_W-1:0] i_window_total,
    input  logic                                i_armed,
    // limit write channel
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [tbrd_pkg::LIMIT_W-1:0]        i_cfg_data,
    // status back to the top
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_LEN = HITS - 1;

    // Shadow copy of the detector state
    tbrd_pkg::t_phase             ph;
    logic [tbrd_pkg::IV_W-1:0]    iv_ring [RING_LEN];
    int                           ring_ptr;
    int                           tally;
    logic [21:0]                  win_sum;
    logic [31:0]                  last_t;
    logic                         rst_latched;
    logic [tbrd_pkg::LIMIT_W-1:0] win_limit;

    tbrd_pkg::t_result            lock_q [$];
    int                           err_tally;
    int                           check_tally;

    function automatic void clear_burst();
        for (int k = 0; k < RING_LEN; k++) iv_ring[k] = '0;
        ring_ptr    = 0;
        tally       = 0;
        win_sum     = '0;
        ph          = tbrd_pkg::PH_IDLE;
        rst_latched = 1'b0;
    endfunction

    // Advance the shadow state by one beat and give the status it should report
    function automatic tbrd_pkg::t_result step_lock(input logic cmd, input logic [31:0] t,
                                                    input logic lvl);
        tbrd_pkg::t_result         res;
        logic [tbrd_pkg::IV_W-1:0] iv;
        logic                      fired;
        fired = 1'b0;
        if (cmd == tbrd_pkg::CMD_RESET) begin
            if (ph == tbrd_pkg::PH_OPEN) clear_burst();
            else rst_latched = 1'b1;
        end else if (lvl && ph != tbrd_pkg::PH_OPEN) begin
            if (ph == tbrd_pkg::PH_IDLE) begin
                // first confirmed hit only arms
                last_t = t;
                tally  = 1;
                ph     = tbrd_pkg::PH_COUNT;
            end else begin
                iv = tbrd_pkg::IV_W'(t - last_t);
                win_sum = win_sum - {6'd0, iv_ring[ring_ptr]} + {6'd0, iv};
                iv_ring[ring_ptr] = iv;
                last_t = t;
                ring_ptr = (ring_ptr == RING_LEN - 1) ? 0 : ring_ptr + 1;
                tally++;
                if (tally >= HITS) begin
                    tally = HITS;
                    if ({10'd0, win_sum} <= win_limit) ph = tbrd_pkg::PH_OPEN;
                end
            end
            fired = (ph == tbrd_pkg::PH_OPEN);
        end
        res.lock_open    = (ph == tbrd_pkg::PH_OPEN);
        res.hits_seen    = tbrd_pkg::HITS_SEEN_W'(tally);
        res.window_total = win_sum[tbrd_pkg::WINDOW_TOTAL_W-1:0];
        res.armed        = (ph != tbrd_pkg::PH_IDLE);
        // a latched reset takes effect right after the firing beat
        if (fired && rst_latched) clear_burst();
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_tally++;
        end
    endfunction

    // Watch all three channels at each edge
    always @(posedge i_clk) begin : watch
        tbrd_pkg::t_result got;
        tbrd_pkg::t_result want;
        if (!i_rst_n) begin
            win_limit = tbrd_pkg::LIMIT_RESET;
            last_t    = '0;
            clear_burst();
            lock_q.delete();
            err_tally   = 0;
            check_tally = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{lock_open: i_lock_open, hits_seen: i_hits_seen,
                        window_total: i_window_total, armed: i_armed};
                if (lock_q.size() == 0) begin
                    $error("result beat with no expected result waiting");
                    err_tally++;
                end else begin
                    want = lock_q.pop_front();
                    check_field("lock_open", int'(want.lock_open), int'(got.lock_open));
                    check_field("hits_seen", int'(want.hits_seen), int'(got.hits_seen));
                    check_field("window_total", int'(want.window_total),
                                int'(got.window_total));
                    check_field("armed", int'(want.armed), int'(got.armed));
                    check_tally++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) win_limit = i_cfg_data;
            if (i_in_valid && i_in_ready)
                lock_q.push_back(step_lock(i_cmd, i_event_time, i_level_confirmed));
        end
        o_pending    <= lock_q.size();
        o_fail_count <= err_tally;
        o_checked    <= check_tally;
    end

    // Anything still waiting at the end is a miss
    final begin
        if (lock_q.size() != 0)
            $error("%0d expected results never arrived", lock_q.size());
    end

endmodule

/* tb/tap_burst_rate_detector_tb.sv */
module tap_burst_rate_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HITS        = 8;
    localparam int PHASE_ITEMS = 180;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tbrd_in_if  in_ch ();
    tbrd_out_if out_ch ();
    tbrd_cfg_if cfg_ch ();

    int                           chk_fails;
    int                           chk_pending;
    int                           chk_checked;
    int                           n_items;
    int                           n_settings;
    int                           quiet;
    bit                           idle_on;
    bit                           hold_out;
    logic [31:0]                  t_now;
    logic [tbrd_pkg::LIMIT_W-1:0] cur_limit;
    logic [tbrd_pkg::LIMIT_W-1:0] limits [6];

    tap_burst_rate_detector #(.HITS(HITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tbrd_lock_checker #(.HITS(HITS)) chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_cmd             (in_ch.cmd),
        .i_event_time      (in_ch.event_time),
        .i_level_confirmed (in_ch.level_confirmed),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_lock_open       (out_ch.lock_open),
        .i_hits_seen       (out_ch.hits_seen),
        .i_window_total    (out_ch.window_total),
        .i_armed           (out_ch.armed),
        .i_cfg_valid       (cfg_ch.valid),
        .i_cfg_ready       (cfg_ch.ready),
        .i_cfg_data        (cfg_ch.data),
        .o_fail_count      (chk_fails),
        .o_pending         (chk_pending),
        .o_checked         (chk_checked)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("tap_burst_rate_detector_tb: errors");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // Result side: random stall bursts, one long hold on request
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_out) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // One input beat, with an optional idle burst ahead of it
    task automatic send_item(input logic cmd, input logic [31:0] t, input logic lvl);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.cmd             <= cmd;
        in_ch.event_time      <= t;
        in_ch.level_confirmed <= lvl;
        do @(posedge i_clk); while (!in_ch.ready);
        n_items++;
    endtask

    // Stop sending and wait out every expected result
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [tbrd_pkg::LIMIT_W-1:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_limit = value;
        n_settings++;
    endtask

    // Mostly tap bursts with intervals around limit/7, plus resets and noise
    task automatic rand_item();
        int unsigned pick;
        int unsigned span;
        logic [31:0] gap;
        pick = $urandom_range(0, 99);
        span = (cur_limit / 7 > 30000) ? 30000 : cur_limit / 7;
        if (pick < 9) begin
            send_item(tbrd_pkg::CMD_RESET, $urandom, 1'($urandom_range(0, 1)));
        end else if (pick < 16) begin
            send_item(tbrd_pkg::CMD_HIT, $urandom, 1'b0);
        end else begin
            if (pick < 76) gap = $urandom_range(0, 2 * span);
            else if (pick < 84) gap = '0;
            else if (pick < 92) gap = $urandom_range(0, 16'hFFFF);
            else gap = $urandom;
            t_now = t_now + gap;
            send_item(tbrd_pkg::CMD_HIT, t_now, 1'b1);
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.cmd             = tbrd_pkg::CMD_HIT;
        in_ch.event_time      = '0;
        in_ch.level_confirmed = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = '0;
        idle_on               = 1'b1;
        hold_out              = 1'b0;
        quiet                 = 0;
        n_items               = 0;
        n_settings            = 0;
        t_now                 = $urandom;
        cur_limit             = tbrd_pkg::LIMIT_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: spurious edge, burst that wraps the tick counter and opens
        send_item(tbrd_pkg::CMD_HIT, 32'hFFFF_FFFF, 1'b0);
        send_item(tbrd_pkg::CMD_HIT, 32'hFFFF_FF00, 1'b1);
        for (int k = 1; k <= 7; k++)
            send_item(tbrd_pkg::CMD_HIT, 32'(32'hFFFF_FF00 + k * 64), 1'b1);
        // hits while open are ignored, then a reset closes
        send_item(tbrd_pkg::CMD_HIT, 32'h0000_0100, 1'b1);
        send_item(tbrd_pkg::CMD_HIT, 32'h0000_0000, 1'b0);
        send_item(tbrd_pkg::CMD_RESET, 32'h0000_0000, 1'b0);
        // early resets latch
        send_item(tbrd_pkg::CMD_RESET, 32'hFFFF_FFFF, 1'b1);
        send_item(tbrd_pkg::CMD_RESET, 32'h5555_5555, 1'b0);
        // widest intervals: full ring, tally saturates, sum at its top
        send_item(tbrd_pkg::CMD_HIT, 32'h0000_0000, 1'b1);
        for (int k = 1; k <= 8; k++) send_item(tbrd_pkg::CMD_HIT, 32'(k * 65535), 1'b1);
        send_item(tbrd_pkg::CMD_HIT, 32'(8 * 65535 + 1), 1'b1);

        // Random phases over several limits; the first fires the latched reset
        limits[0] = 32'hFFFF_FFFF;
        limits[1] = 32'd0;
        limits[2] = $urandom_range(200, 3000);
        limits[3] = 32'd1000;
        limits[4] = $urandom;
        limits[5] = 32'd700;
        for (int p = 0; p < 6; p++) begin
            set_limit(limits[p]);
            if (p == 2) begin
                // long result stall while input keeps coming
                idle_on  = 1'b0;
                hold_out = 1'b1;
                repeat (40) rand_item();
                idle_on  = 1'b1;
            end
            if (p == 5) idle_on = 1'b0;
            repeat (PHASE_ITEMS) rand_item();
        end

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("run covered %0d input beats across %0d limit settings, %0d results checked",
                 n_items, n_settings, chk_checked);
        if (chk_fails == 0) begin
            $display("tap_burst_rate_detector_tb: clean");
        end else begin
            $display("tap_burst_rate_detector_tb: errors");
        end
        $finish;
    end

endmodule
